/* src/dklk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dklk_pkg: shared types and constants of the two-key combination lock
// Widths, register indexes, reset values and mask helpers.
// ----------------------------------------------------------------------------
package dklk_pkg;

    localparam int MAX_CODE_BITS = 16;
    localparam int HISTORY_BITS  = 8;

    localparam int DEB_W   = 4;
    localparam int LEN_W   = 5;
    localparam int CFG_W   = 5;
    localparam int INDEX_W = 2;

    // register indexes of the configuration port
    localparam logic [INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [INDEX_W-1:0] REG_CODE_LEN = 2'd1;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 4'd6;
    localparam logic [LEN_W-1:0] CODE_LEN_RESET = 5'd6;

    // new debounced presses found by the two key lanes
    typedef struct packed {
        logic key1;
        logic key0;
    } press_t;

    // one result item, last field in the lowest bits
    typedef struct packed {
        logic             locked_now;
        logic             unlocked_now;
        logic             wrong_code;
        logic [LEN_W-1:0] entry_count;
        logic             press_taken;
        logic             locked;
    } result_t;

    // ones in the low n bits of the sample history
    function automatic logic [HISTORY_BITS-1:0] window_mask(input logic [DEB_W-1:0] n);
        logic [HISTORY_BITS-1:0] m;
        for (int i = 0; i < HISTORY_BITS; i++) begin
            m[i] = (DEB_W'(i) < n);
        end
        return m;
    endfunction

    // ones in the low n bits of a code word
    function automatic logic [MAX_CODE_BITS-1:0] code_mask(input logic [LEN_W-1:0] n);
        logic [MAX_CODE_BITS-1:0] m;
        for (int i = 0; i < MAX_CODE_BITS; i++) begin
            m[i] = (LEN_W'(i) < n);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* src/dklk_debounce.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dklk_debounce: one key lane
// Keeps the sample history and debounced level of one key and flags a new
// debounced press in the tick that completes it.
// ----------------------------------------------------------------------------
module dklk_debounce
    import dklk_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             level,
    input  wire logic [DEB_W-1:0] deb_eff,
    output logic                  press
);

    logic [HISTORY_BITS-1:0] hist_reg;
    logic [HISTORY_BITS-1:0] hist_next;
    logic                    held_reg;
    logic                    held_next;
    logic [HISTORY_BITS-1:0] win;
    logic                    all_on;
    logic                    all_off;

    // shift in the new sample and look at the window
    always_comb
    begin
        win       = window_mask(deb_eff);
        hist_next = {hist_reg[HISTORY_BITS-2:0], level};
        all_on    = ((hist_next & win) == win);
        all_off   = ((hist_next & win) == '0);
        press     = all_on && !held_reg;
        held_next = held_reg;
        if (all_on)
        begin
            held_next = 1'b1;
        end
        else if (all_off)
        begin
            held_next = 1'b0;
        end
    end

    // lane state moves only on an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            held_reg <= 1'b0;
        end
        else if (step)
        begin
            hist_reg <= hist_next;
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

/* src/dklk_entry.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dklk_entry: merge of the key lanes into the code entry
// Records presses (key0 first), stores or checks a full entry and keeps
// the lock mode.
// ----------------------------------------------------------------------------
module dklk_entry
    import dklk_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire press_t           press,
    input  wire logic [LEN_W-1:0] len_eff,
    output result_t               result
);

    logic                     lock_reg;
    logic                     lock_next;
    logic [MAX_CODE_BITS-1:0] code_reg;
    logic [MAX_CODE_BITS-1:0] code_next;
    logic [MAX_CODE_BITS-1:0] bits_reg;
    logic [MAX_CODE_BITS-1:0] bits_next;
    logic [LEN_W-1:0]         cnt_reg;
    logic [LEN_W-1:0]         cnt_next;
    logic [MAX_CODE_BITS-1:0] m;
    logic                     taken;
    logic                     wrong;
    logic                     opened;
    logic                     closed;

    // record presses, then act on a full entry
    always_comb
    begin
        m         = code_mask(len_eff);
        lock_next = lock_reg;
        code_next = code_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        taken     = 1'b0;
        wrong     = 1'b0;
        opened    = 1'b0;
        closed    = 1'b0;
        if (press.key0 && (cnt_next < len_eff))
        begin
            bits_next = {bits_next[MAX_CODE_BITS-2:0], 1'b1};
            cnt_next  = cnt_next + LEN_W'(1);
            taken     = 1'b1;
        end
        if (press.key1 && (cnt_next < len_eff))
        begin
            bits_next = {bits_next[MAX_CODE_BITS-2:0], 1'b0};
            cnt_next  = cnt_next + LEN_W'(1);
            taken     = 1'b1;
        end
        if (cnt_next >= len_eff)
        begin
            if (!lock_reg)
            begin
                code_next = bits_next & m;
                lock_next = 1'b1;
                closed    = 1'b1;
            end
            else if ((bits_next & m) == (code_reg & m))
            begin
                code_next = '0;
                lock_next = 1'b0;
                opened    = 1'b1;
            end
            else
            begin
                wrong = 1'b1;
            end
            bits_next = '0;
            cnt_next  = '0;
        end
        result.locked       = lock_next;
        result.press_taken  = taken;
        result.entry_count  = cnt_next;
        result.wrong_code   = wrong;
        result.unlocked_now = opened;
        result.locked_now   = closed;
    end

    // entry and lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg <= 1'b0;
            code_reg <= '0;
            bits_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (step)
        begin
            lock_reg <= lock_next;
            code_reg <= code_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
`default_nettype wire

/* src/debounced_two_key_combination_lock_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_two_key_combination_lock_unit: two-key combination lock
// Each input transfer is one sample tick of both keys: s_tdata bit 0 is
// key0, bit 1 is key1. Two debounce lanes work side by side, one per key,
// and the entry stage merges their presses into the code entry.
// Every input transfer gives exactly one result transfer on m_*.
// The block takes one item per cycle while s_tready is high; lane
// update, entry and code compare all settle in the cycle of the input
// transfer. Results wait in a two-entry output queue, so the block still
// takes one more item while a result is stalled; s_tready drops only
// with two results waiting on a stalled receiver. Configuration
// (cfg_wr_en, cfg_index, cfg_data) is to be written by the user while
// idle; the block does not enforce it. Index 0 debounce_samples, index 1
// code_length; other indexes ignored. Reset: histories, debounced levels,
// entry and stored code cleared, setting mode, debounce_samples and
// code_length back to 6, queue empty.
// ----------------------------------------------------------------------------
module debounced_two_key_combination_lock_unit
    import dklk_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [0] key0_level, [1] key1_level
    // output stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,   // [0] locked, [1] press_taken,
                                               // [6:2] entry_count, [7] wrong_code,
                                               // [8] unlocked_now, [9] locked_now
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    logic [DEB_W-1:0] deb_reg;
    logic [LEN_W-1:0] len_reg;
    logic [DEB_W-1:0] deb_eff;
    logic [LEN_W-1:0] len_eff;
    logic             step;
    press_t           press;
    result_t          result;
    result_t          head_reg;
    result_t          tail_reg;
    logic [1:0]       cnt_reg;
    logic             pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg <= DEBOUNCE_RESET;
            len_reg <= CODE_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEBOUNCE: deb_reg <= cfg_data[DEB_W-1:0];
                REG_CODE_LEN: len_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // clamp the settings to their working ranges
    always_comb
    begin
        deb_eff = deb_reg;
        if (deb_reg == '0)
        begin
            deb_eff = DEB_W'(1);
        end
        else if (deb_reg > DEB_W'(HISTORY_BITS))
        begin
            deb_eff = DEB_W'(HISTORY_BITS);
        end
        len_eff = len_reg;
        if (len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_CODE_BITS))
        begin
            len_eff = LEN_W'(MAX_CODE_BITS);
        end
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign step     = s_tvalid && s_tready;

    // key lanes
    dklk_debounce u_lane0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .level   (s_tdata[0]),
        .deb_eff (deb_eff),
        .press   (press.key0)
    );

    dklk_debounce u_lane1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .level   (s_tdata[1]),
        .deb_eff (deb_eff),
        .press   (press.key1)
    );

    // merge stage
    dklk_entry u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .press   (press),
        .len_eff (len_eff),
        .result  (result)
    );

    // two-entry output queue
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {6'd0, head_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (step && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !step)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (step && !pop)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_reg <= result;
            end
            else
            begin
                tail_reg <= result;
            end
        end
        else if (pop && !step)
        begin
            head_reg <= tail_reg;
        end
        else if (pop && step)
        begin
            if (cnt_reg == 2'd1)
            begin
                head_reg <= result;
            end
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= result;
            end
        end
    end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the debounced two-key combination lock
// Sends key sample ticks as stream transfers and tracks the expected lock
// behavior in a scoreboard that runs its own copy of the debounce lanes,
// entry shift register and stored code. Every result transfer is compared
// field by field. A short directed run is followed by random press
// sequences under several debounce and code length settings, with random
// gaps on both sides, a long receiver hold-off and a drained sender pause.
// ----------------------------------------------------------------------------
module tb_top;
    import dklk_pkg::*;

    // spare register indexes, writes there must have no effect
    localparam logic [INDEX_W-1:0] REG_UNUSED2 = 2'd2;
    localparam logic [INDEX_W-1:0] REG_UNUSED3 = 2'd3;

    // register settings and item budget of each random phase
    localparam int PHASES = 10;
    localparam int PHASE_DEB[PHASES]   = '{1, 18, 15, 2, 3, 6, 1, 8, 5, 4};
    localparam int PHASE_LEN[PHASES]   = '{3, 1, 2, 31, 4, 6, 0, 16, 5, 2};
    localparam int PHASE_ITEMS[PHASES] = '{100, 60, 100, 160, 90, 110, 50, 90, 100, 80};
    localparam int PAUSE_PHASE = 2;
    localparam int HOLD_PHASE  = 5;
    localparam int HOLD_CYCLES = 80;

    // expected lock behavior, advanced on every accepted sample transfer
    class lock_tracker;
        logic [DEB_W-1:0]         debounce_reg;
        logic [LEN_W-1:0]         length_reg;
        logic [HISTORY_BITS-1:0]  hist0;
        logic [HISTORY_BITS-1:0]  hist1;
        logic                     held0;
        logic                     held1;
        logic                     locked_mode;
        logic [MAX_CODE_BITS-1:0] code_word;
        logic [MAX_CODE_BITS-1:0] entry_word;
        logic [LEN_W-1:0]         count;
        result_t                  due_results[$];
        int                       errors;

        function new();
            debounce_reg = DEBOUNCE_RESET;
            length_reg   = CODE_LEN_RESET;
            hist0        = '0;
            hist1        = '0;
            held0        = 1'b0;
            held1        = 1'b0;
            locked_mode  = 1'b0;
            code_word    = '0;
            entry_word   = '0;
            count        = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_DEBOUNCE: debounce_reg = value[DEB_W-1:0];
                REG_CODE_LEN: length_reg = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // effective window, clamped to 1..HISTORY_BITS
        function int debounce_len();
            int n;
            n = int'(debounce_reg);
            if (n < 1) n = 1;
            if (n > HISTORY_BITS) n = HISTORY_BITS;
            return n;
        endfunction

        // effective entry length, clamped to 1..MAX_CODE_BITS
        function int entry_len();
            int n;
            n = int'(length_reg);
            if (n < 1) n = 1;
            if (n > MAX_CODE_BITS) n = MAX_CODE_BITS;
            return n;
        endfunction

        // one key lane: returns 1 on a new debounced press
        function logic lane_step(inout logic [HISTORY_BITS-1:0] hist, inout logic held,
                                 input logic level, input int n);
            logic [HISTORY_BITS-1:0] win;
            win  = HISTORY_BITS'((1 << n) - 1);
            hist = {hist[HISTORY_BITS-2:0], level};
            if ((hist & win) == win) begin
                if (!held) begin
                    held = 1'b1;
                    return 1'b1;
                end
            end
            else if ((hist & win) == '0) begin
                held = 1'b0;
            end
            return 1'b0;
        endfunction

        // shift one press into the entry unless it is full
        function logic record_press(logic b, int len);
            if (int'(count) >= len) return 1'b0;
            entry_word = {entry_word[MAX_CODE_BITS-2:0], b};
            count++;
            return 1'b1;
        endfunction

        function void note_sample(logic k0, logic k1);
            int                       n;
            int                       len;
            logic                     p0;
            logic                     p1;
            logic [MAX_CODE_BITS-1:0] m;
            result_t                  r;
            n   = debounce_len();
            len = entry_len();
            p0  = lane_step(hist0, held0, k0, n);
            p1  = lane_step(hist1, held1, k1, n);
            r   = '0;
            // key0 goes first when both press in the same tick
            if (p0) r.press_taken = record_press(1'b1, len) | r.press_taken;
            if (p1) r.press_taken = record_press(1'b0, len) | r.press_taken;
            // full entry: store, unlock or flag a wrong code
            if (int'(count) >= len) begin
                m = MAX_CODE_BITS'((1 << len) - 1);
                if (!locked_mode) begin
                    code_word   = entry_word & m;
                    locked_mode = 1'b1;
                    r.locked_now = 1'b1;
                end
                else if ((entry_word & m) == (code_word & m)) begin
                    code_word   = '0;
                    locked_mode = 1'b0;
                    r.unlocked_now = 1'b1;
                end
                else begin
                    r.wrong_code = 1'b1;
                end
                entry_word = '0;
                count      = '0;
            end
            r.locked      = locked_mode;
            r.entry_count = count;
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [15:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[9:0]);
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %h",
                         $time, data);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("locked", int'(want.locked), int'(got.locked));
            compare_field("press_taken", int'(want.press_taken), int'(got.press_taken));
            compare_field("entry_count", int'(want.entry_count), int'(got.entry_count));
            compare_field("wrong_code", int'(want.wrong_code), int'(got.wrong_code));
            compare_field("unlocked_now", int'(want.unlocked_now), int'(got.unlocked_now));
            compare_field("locked_now", int'(want.locked_now), int'(got.locked_now));
            compare_field("padding", 0, int'(data[15:10]));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;
    logic               cfg_wr_en = 1'b0;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    lock_tracker tracker = new();
    int          sent_count = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          hold_req = 1'b0;

    debounced_two_key_combination_lock_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    // result receiver with random stalls and one long hold-off
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (rx_burst) stall = 0;
            else stall = $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // one sample tick as an input transfer
    task automatic send_sample(input logic k0, input logic k1);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, k1, k0};
        do @(posedge clk); while (!s_tready);
        tracker.note_sample(k0, k1);
        sent_count++;
    endtask

    task automatic send_run(input logic k0, input logic k1, input int n);
        repeat (n) send_sample(k0, k1);
    endtask

    // register write, enable stays high across back-to-back writes
    task automatic cfg_write(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value,
                             input bit last);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.write_reg(idx, value);
        if (last) cfg_wr_en <= 1'b0;
    endtask

    // stop sending and let every expected result come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one key press: optional bounce, hold, release
    task automatic press_sequence();
        int   n;
        int   len;
        int   hold;
        int   pick;
        int   bit_pos;
        logic k0;
        logic k1;
        // contact bounce ahead of the press
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        n   = tracker.debounce_len();
        len = tracker.entry_len();
        // when locked, mostly follow the stored code
        if (tracker.locked_mode && int'(tracker.count) < len && $urandom_range(0, 3) != 0) begin
            bit_pos = len - 1 - int'(tracker.count);
            k0 = tracker.code_word[bit_pos];
            k1 = !k0;
        end
        else begin
            pick = $urandom_range(0, 5);
            k0 = (pick <= 2) || (pick == 5);
            k1 = (pick >= 3);
        end
        hold = n + $urandom_range(0, 3);
        // some presses too short to pass the debounce
        if (n > 1 && $urandom_range(0, 9) == 0) hold = $urandom_range(1, n - 1);
        send_run(k0, k1, hold);
        send_run(1'b0, 1'b0, n + $urandom_range(0, 3));
    endtask

    task automatic run_phase(input int idx);
        int phase_end;
        int mid;
        bit paused;
        wait_drained();
        cfg_write((idx % 2 != 0) ? REG_UNUSED3 : REG_UNUSED2, CFG_W'($urandom), 1'b0);
        cfg_write(REG_DEBOUNCE, CFG_W'(PHASE_DEB[idx]), 1'b0);
        cfg_write(REG_CODE_LEN, CFG_W'(PHASE_LEN[idx]), 1'b1);
        tx_burst  = (idx == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
        rx_burst  = ($urandom_range(0, 3) == 0);
        if (idx == HOLD_PHASE) hold_req = 1'b1;
        phase_end = sent_count + PHASE_ITEMS[idx];
        mid       = sent_count + PHASE_ITEMS[idx] / 2;
        paused    = 1'b0;
        while (sent_count < phase_end)
        begin
            // sender pause until the output side is empty
            if (idx == PAUSE_PHASE && !paused && sent_count >= mid) begin
                s_tvalid <= 1'b0;
                while (tracker.due_results.size() != 0) @(posedge clk);
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6))
                    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                press_sequence();
        end
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-sample debounce, two-press code
        cfg_write(REG_DEBOUNCE, CFG_W'(1), 1'b0);
        cfg_write(REG_CODE_LEN, CFG_W'(2), 1'b1);
        // set the code 10 and lock
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        // both keys in one tick, key0 first, opens the lock
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        // held key counts once, then lock again
        send_run(1'b1, 1'b0, 3);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        // wrong code
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        // second key ignored once the entry is full
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        // debounce of zero, partial entry, then length lowered below the count
        wait_drained();
        cfg_write(REG_DEBOUNCE, CFG_W'(0), 1'b0);
        cfg_write(REG_CODE_LEN, CFG_W'(5), 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        wait_drained();
        cfg_write(REG_CODE_LEN, CFG_W'(1), 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);

        // random phases
        for (int i = 0; i < PHASES; i++) run_phase(i);

        wait_drained();
        repeat (8) @(posedge clk);
        if (tracker.due_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, tracker.due_results.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* debounced_two_key_combination_lock_unit.f */
src/dklk_pkg.sv
src/dklk_debounce.sv
src/dklk_entry.sv
src/debounced_two_key_combination_lock_unit.sv
tb/tb_top.sv
